@@ hdl/mastp_pkg.sv @@
// Shared constants and types for the multi-axis step pulse planner.
package mastp_pkg;
  localparam int unsigned NUM_AXES_DEF    = 4;
  localparam int unsigned RING_DEPTH_DEF  = 16;
  localparam int unsigned FRAME_TICKS_DEF = 1024;
  localparam int unsigned NEVER_TICKS_DEF = 65535;

  localparam int unsigned POS_W   = 48;
  localparam int unsigned IN_AXES = 4;
  localparam logic [47:0] HALF_STEP = 48'd32768;
  localparam logic [31:0] ONE_TICK_Q5 = 32'd32;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_PREP    = 11'b00000000010,
    S_DIV     = 11'b00000000100,
    S_PHASE   = 11'b00000001000,
    S_TOTAL   = 11'b00000010000,
    S_STORE   = 11'b00000100000,
    S_MIN     = 11'b00001000000,
    S_SUB     = 11'b00010000000,
    S_LOAD    = 11'b00100000000,
    S_STEP    = 11'b01000000000,
    S_OUT     = 11'b10000000000
  } state_t;
endpackage

@@ hdl/multi_axis_step_pulse_planner_top.sv @@
// Top level of the multi-axis step pulse planner: sequencer, ring and shared divider.
//
//  channel | dir | handshake      | payload
//  s_axis  | in  | tvalid/tready  | tuser=opcode, tdata=target_x,y,z,e (192b)
//  m_axis  | out | tvalid/tready  | tdata=step_mask,dir_mask,wait_ticks,idle (32b)
//
// Enqueue: per axis, prep, divide, then phase, total, frame check and store; a zero
// distance ends the divide at its first quotient bit and an axis with no step skips
// the frame check.
// The divider is radix-2 restoring, one quotient bit a cycle, and shared by all axes.
// Advance: accept, minimum search over the axes, subtract, frame check, then load and
// step for each axis; when the ring is empty at frame end the result is idle and the
// frame check ends the word, with no load or step pass. Input is taken only in the idle state.
// A result waits in the output register; the next word is taken only after it
// leaves. rst clears countdowns, ring indices and positions; no clearing pass.
module multi_axis_step_pulse_planner_top
  import mastp_pkg::*;
#(
  parameter int unsigned NUM_AXES    = NUM_AXES_DEF,
  parameter int unsigned RING_DEPTH  = RING_DEPTH_DEF,
  parameter int unsigned FRAME_TICKS = FRAME_TICKS_DEF,
  parameter int unsigned NEVER_TICKS = NEVER_TICKS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,   // target_x, target_y, target_z, target_e
  input  logic         s_axis_tuser,   // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata    // step_mask, dir_mask, wait_ticks, idle, pad
);
  localparam int unsigned AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int unsigned RW = $clog2(RING_DEPTH);
  localparam int unsigned DW = RW + AW;
  localparam logic [31:0] FRAME_Q5  = 32'(FRAME_TICKS) << 5;
  localparam logic [31:0] DIVIDEND  = 32'(FRAME_TICKS) << 21;
  localparam logic [15:0] NEVER16   = 16'(NEVER_TICKS);
  localparam logic [AW-1:0] LAST_AX = AW'(NUM_AXES - 1);

  state_t state;

  // per-axis state, mostly read at the axis counter; the subtract step updates every countdown
  logic [47:0] cur_pos [NUM_AXES];
  logic [31:0] axis_cd [NUM_AXES];
  logic [15:0] axis_per [NUM_AXES];
  logic [31:0] frame_cd;
  logic [NUM_AXES-1:0] active_dir;
  logic [RW-1:0] head, tail;

  // plan ring memories: first and interval addressed by {slot, axis}, directions by slot
  logic [15:0] mem_first [2**DW];
  logic [15:0] mem_intv  [2**DW];
  logic [NUM_AXES-1:0] mem_dir [RING_DEPTH];
  logic [15:0] rd_first, rd_intv;
  logic [NUM_AXES-1:0] rd_dir;

  logic [191:0] tgt;
  logic [AW-1:0] ax;
  logic [NUM_AXES-1:0] dirs, steps;

  // enqueue datapath registers
  logic [31:0] delta, cp, np, quo, rem, stp, intv, first_r;
  logic [5:0]  dcnt;
  logic        no_step;

  // advance registers
  logic [31:0] nxt, rnd;
  logic        load;

  logic [31:0] out_data;
  logic        out_valid;

  logic [RW-1:0] head_inc, tail_inc;
  assign head_inc = (32'(head) + 32'd1 == 32'(RING_DEPTH)) ? '0 : head + RW'(1);
  assign tail_inc = (32'(tail) + 32'd1 == 32'(RING_DEPTH)) ? '0 : tail + RW'(1);

  assign s_axis_tready = (state == S_IDLE) && !out_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // target of the axis under work; axes past the input fields aim at zero
  logic [47:0] tgt_ax;
  always_comb begin
    tgt_ax = '0;
    for (int i = 0; i < IN_AXES; i++) begin
      if (32'(ax) == i) begin
        tgt_ax = tgt[i*48 +: 48];
      end
    end
  end

  // half-step offsets and the absolute distance
  logic [48:0] oc, on, dd, ad;
  logic [15:0] cpr, npr;
  assign oc  = {cur_pos[ax][47], cur_pos[ax]} + {1'b0, HALF_STEP};
  assign on  = {tgt_ax[47], tgt_ax} + {1'b0, HALF_STEP};
  assign dd  = on - oc;
  assign ad  = dd[48] ? (~dd + 49'd1) : dd;
  assign cpr = oc[15:0];
  assign npr = on[15:0];

  // shared divider step
  logic [32:0] rsh, rtry;
  assign rsh  = {rem, quo[31]};
  assign rtry = rsh - {1'b0, delta};

  logic [63:0] prod;
  logic [31:0] first_sum;
  assign prod      = intv * (state == S_TOTAL ? cp : stp);
  assign first_sum = first_r + prod[31:0];

  logic [DW-1:0] waddr;
  assign waddr = {head, ax};

  // read one axis ahead while stepping so rd_* match the axis under work
  logic [AW-1:0] rd_ax;
  assign rd_ax = (state == S_STEP) ? ax + AW'(1) : ax;

  // fold the last axis' step decision into the mask
  function automatic logic [NUM_AXES-1:0] step_fin(
    input logic [NUM_AXES-1:0] s, input logic [AW-1:0] a, input logic ld,
    input logic [15:0] f, input logic [31:0] fc, input logic [31:0] cd);
    logic [NUM_AXES-1:0] r;
    r    = s;
    r[a] = ld ? (32'(f) + fc < ONE_TICK_Q5) : (cd < ONE_TICK_Q5);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (state == S_STORE) begin
      mem_first[waddr] <= first_r[15:0];
      mem_intv[waddr]  <= no_step ? NEVER16 :
                          (intv > 32'(NEVER_TICKS) ? NEVER16 : intv[15:0]);
      if (ax == LAST_AX) begin
        mem_dir[head] <= dirs;
      end
    end
    rd_first <= mem_first[{tail, rd_ax}];
    rd_intv  <= mem_intv[{tail, rd_ax}];
    rd_dir   <= mem_dir[tail];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      head      <= '0;
      tail      <= '0;
      frame_cd  <= '0;
      active_dir <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        cur_pos[i]  <= '0;
        axis_cd[i]  <= '0;
        axis_per[i] <= NEVER16;
      end
    end else begin
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            tgt  <= s_axis_tdata;
            ax   <= '0;
            dirs <= '0;
            steps <= '0;
            if (s_axis_tuser == OP_ENQUEUE) begin
              // drop the whole frame when the ring is full
              if (head_inc != tail) begin
                state <= S_PREP;
              end
            end else begin
              nxt   <= frame_cd;
              state <= S_MIN;
            end
          end
        end
        S_PREP: begin
          delta <= (ad > 49'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : ad[31:0];
          cp    <= dd[48] ? (32'd65536 - 32'(cpr)) : 32'(cpr);
          np    <= dd[48] ? (32'd65536 - 32'(npr)) : 32'(npr);
          dirs[ax] <= !dd[48];
          cur_pos[ax] <= tgt_ax;
          quo   <= DIVIDEND;
          rem   <= '0;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (dcnt == 6'd0) begin
            stp <= ((32'(delta[31:16]) + ((cp > np) ? 32'd1 : 32'd0)) > 32'hFFFF) ?
                   32'hFFFF : (32'(delta[31:16]) + ((cp > np) ? 32'd1 : 32'd0));
          end
          if (rtry[32]) begin
            rem <= rsh[31:0];
            quo <= {quo[30:0], 1'b0};
          end else begin
            rem <= rtry[31:0];
            quo <= {quo[30:0], 1'b1};
          end
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd31 || delta == 32'd0) begin
            state <= S_PHASE;
          end
          no_step <= (delta == 32'd0) ||
                     (delta[31:16] == 16'd0 && !(cp > np));
        end
        S_PHASE: begin
          intv    <= quo;
          state   <= S_TOTAL;
        end
        S_TOTAL: begin
          // first = interval - interval*phase>>16, kept in 16 bits
          if (no_step) begin
            first_r <= 32'(NEVER16);
            state   <= S_STORE;
          end else begin
            first_r <= 32'((intv - prod[47:16]) & 32'hFFFF);
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          // raise first past the frame end if the last step would land inside;
          // the sum is compared as a signed value
          if (first_sum[31] || first_sum <= FRAME_Q5) begin
            first_r <= 32'((first_r + FRAME_Q5 - first_sum + 32'd1) & 32'hFFFF);
          end
          state <= S_STORE;
        end
        S_STORE: begin
          if (ax == LAST_AX) begin
            head  <= head_inc;
            state <= S_IDLE;
          end else begin
            ax    <= ax + AW'(1);
            state <= S_PREP;
          end
        end
        S_MIN: begin
          if (axis_cd[ax] < nxt) begin
            nxt <= axis_cd[ax];
          end
          if (ax == LAST_AX) begin
            ax    <= '0;
            state <= S_SUB;
          end else begin
            ax <= ax + AW'(1);
          end
        end
        S_SUB: begin
          rnd <= nxt & ~(ONE_TICK_Q5 - 32'd1);
          frame_cd <= frame_cd - (nxt & ~(ONE_TICK_Q5 - 32'd1));
          for (int i = 0; i < NUM_AXES; i++) begin
            axis_cd[i] <= axis_cd[i] - (nxt & ~(ONE_TICK_Q5 - 32'd1));
          end
          load   <= 1'b0;
          ax     <= '0;
          state  <= S_LOAD;
        end
        S_LOAD: begin
          if (frame_cd < ONE_TICK_Q5) begin
            if (tail == head) begin
              frame_cd <= 32'(NEVER_TICKS);
              for (int i = 0; i < NUM_AXES; i++) begin
                axis_cd[i] <= 32'(NEVER_TICKS);
              end
              out_data <= {7'd0, 1'b1, 16'(rnd >> 5), 4'(active_dir), 4'd0};
              out_valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              load  <= 1'b1;
              state <= S_STEP;
            end
          end else begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          // rd_* hold entry {tail, ax}, fetched in the previous cycle
          if (load) begin
            axis_per[ax] <= rd_intv;
            if (32'(rd_first) + frame_cd < ONE_TICK_Q5) begin
              steps[ax] <= 1'b1;
              axis_cd[ax] <= 32'(rd_first) + frame_cd + 32'(rd_intv);
            end else begin
              axis_cd[ax] <= 32'(rd_first) + frame_cd;
            end
          end else if (axis_cd[ax] < ONE_TICK_Q5) begin
            steps[ax] <= 1'b1;
            axis_cd[ax] <= axis_cd[ax] + 32'(axis_per[ax]);
          end
          if (ax == LAST_AX) begin
            if (load) begin
              active_dir <= rd_dir;
              tail       <= tail_inc;
              frame_cd   <= frame_cd + FRAME_Q5;
            end
            state <= S_IDLE;
            out_valid <= 1'b1;
            out_data <= {7'd0, 1'b0, 16'(rnd >> 5),
                         4'(load ? rd_dir : active_dir), 4'(step_fin(steps, ax, load,
                         rd_first, frame_cd, axis_cd[ax]))};
          end else begin
            ax <= ax + AW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hdl/mastp_checker.sv @@
// Port-level checker for the step pulse planner, bound to the top level.
module mastp_checker
  import mastp_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [31:0]  m_axis_tdata
);
  a_no_take_while_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("input taken while out busy");
  a_idle_no_steps: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[24] |-> m_axis_tdata[3:0] == 4'd0) else $error("idle with steps");
  a_enq_no_out: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_ENQUEUE |=> !m_axis_tvalid)
    else $error("result after enqueue");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[31:25] == 7'd0) else $error("pad bits set");
endmodule

bind multi_axis_step_pulse_planner_top mastp_checker u_mastp_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_tuser(s_axis_tuser), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

@@ sim/mastp_checker.sv @@
// Checker for the step pulse planner: predicts results from accepted words and compares.
`timescale 1ns / 1ps
module mastp_scoreboard
  import mastp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [31:0]  m_axis_tdata,
  output int           fail_count,
  output int           pending
);
  localparam int NA = 4;
  localparam int RD = 16;
  localparam logic [31:0] FRAME_Q5 = 32'd1024 << 5;
  localparam logic [15:0] NEVER = 16'hFFFF;

  typedef struct packed {
    logic       idle;
    logic [15:0] wait_ticks;
    logic [3:0] dir_mask;
    logic [3:0] step_mask;
  } pulse_t;

  logic signed [47:0] pos [NA];
  logic [15:0] r_first [RD][NA];
  logic [15:0] r_intv [RD][NA];
  logic [3:0]  r_dir [RD];
  int unsigned head, tail;
  logic [31:0] frame_cd;
  logic [31:0] axis_cd [NA];
  logic [15:0] period [NA];
  logic [3:0]  act_dir;
  pulse_t pulse_q[$];

  // Work out one axis of a new plan into the given ring slot.
  task automatic plan_axis(input int a, input logic signed [47:0] tgt, input int slot,
                           inout logic [3:0] dirs);
    logic signed [63:0] oc, on, d;
    logic [63:0] ad;
    logic [31:0] delta, cp, np, steps, intv, phase, t;
    logic [15:0] first;
    logic fwd;
    oc = 64'(pos[a]) + 64'sd32768;
    on = 64'(tgt) + 64'sd32768;
    fwd = on >= oc;
    d = on - oc;
    ad = d < 0 ? -d : d;
    delta = ad > 64'hFFFFFFFF ? 32'hFFFFFFFF : ad[31:0];
    cp = {16'd0, oc[15:0]};
    np = {16'd0, on[15:0]};
    pos[a] = tgt;
    if (fwd) dirs[a] = 1'b1;
    else begin
      cp = 32'd65536 - cp;
      np = 32'd65536 - np;
    end
    steps = (delta >> 16) + (cp > np ? 32'd1 : 32'd0);
    if (steps > 32'hFFFF) steps = 32'hFFFF;
    if (steps == 0 || delta == 0) begin
      r_first[slot][a] = NEVER;
      r_intv[slot][a] = NEVER;
      return;
    end
    intv = (32'd1024 << 21) / delta;
    phase = 32'((64'(intv) * 64'(cp)) >> 16);
    first = 16'(intv - phase);
    t = 32'(first) + intv * steps;
    // signed compare against frame end
    if ($signed(t) <= $signed(FRAME_Q5)) first = 16'(32'(first) + FRAME_Q5 - t + 32'd1);
    r_first[slot][a] = first;
    r_intv[slot][a] = intv > 32'hFFFF ? NEVER : intv[15:0];
  endtask

  task automatic predict_word(input logic op, input logic [191:0] data);
    logic [3:0] dirs, steps;
    logic [31:0] nxt, rnd;
    int slot;
    pulse_t p;
    if (op == OP_ENQUEUE) begin
      slot = head;
      dirs = '0;
      if ((slot + 1) % RD == tail) return;   // drop on full ring
      for (int a = 0; a < NA; a++) plan_axis(a, data[48*a +: 48], slot, dirs);
      r_dir[slot] = dirs;
      head = (slot + 1) % RD;
      return;
    end
    nxt = frame_cd;
    for (int a = 0; a < NA; a++) if (axis_cd[a] < nxt) nxt = axis_cd[a];
    rnd = nxt & ~32'd31;
    frame_cd -= rnd;
    for (int a = 0; a < NA; a++) axis_cd[a] -= rnd;
    steps = '0;
    if (frame_cd < 32) begin
      slot = tail;
      if (slot == head) begin
        frame_cd = 32'(NEVER);
        for (int a = 0; a < NA; a++) axis_cd[a] = 32'(NEVER);
        p = '{idle: 1'b1, wait_ticks: rnd[20:5], dir_mask: act_dir, step_mask: 4'd0};
        pulse_q.push_back(p);
        return;
      end
      tail = (slot + 1) % RD;
      act_dir = r_dir[slot];
      for (int a = 0; a < NA; a++) begin
        period[a] = r_intv[slot][a];
        axis_cd[a] = 32'(r_first[slot][a]) + frame_cd;
      end
      frame_cd += FRAME_Q5;
    end
    for (int a = 0; a < NA; a++)
      if (axis_cd[a] < 32) begin
        steps[a] = 1'b1;
        axis_cd[a] += 32'(period[a]);
      end
    p = '{idle: 1'b0, wait_ticks: rnd[20:5], dir_mask: act_dir, step_mask: steps};
    pulse_q.push_back(p);
  endtask

  assign pending = pulse_q.size();

  always @(posedge clk) begin
    pulse_t got, exp_p;
    if (rst) begin
      for (int a = 0; a < NA; a++) begin
        pos[a] = '0;
        axis_cd[a] = '0;
        period[a] = NEVER;
      end
      head = 0;
      tail = 0;
      frame_cd = '0;
      act_dir = '0;
      fail_count <= 0;
      pulse_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_word(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[24:0];
        if (pulse_q.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_p = pulse_q.pop_front();
          if (got !== exp_p) begin
            $display("%0t: exp s=%h d=%h w=%0d i=%b got s=%h d=%h w=%0d i=%b",
                     $time, exp_p.step_mask, exp_p.dir_mask, exp_p.wait_ticks, exp_p.idle,
                     got.step_mask, got.dir_mask, got.wait_ticks, got.idle);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ sim/multi_axis_step_pulse_planner_top_test.sv @@
// Testbench top for the step pulse planner: drives enqueue and advance words, gives verdict.
`timescale 1ns / 1ps
module multi_axis_step_pulse_planner_top_test
  import mastp_pkg::*;
();

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [31:0]  m_axis_tdata;
  int           fail_count;
  int           pending;
  int           send_idle_pct;
  int           recv_idle_pct;
  longint       cycle_count;
  logic signed [47:0] last_tgt [4];

  multi_axis_step_pulse_planner_top dut (.*);

  mastp_scoreboard checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Guard against a hang: far above the slowest correct run.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 64'd2000000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver stalls at random, at the rate the current phase sets.
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Put a word on the bus and hold it until taken; idle first at random.
  // Returns at the falling edge after the handshake with valid still high,
  // so the next word or an idle cycle replaces it at that same edge.
  task automatic send_word(input logic op, input logic [191:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= data;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Pick a target near the last one so steps stay in realistic ranges;
  // now and then jump anywhere in the field.
  function automatic logic [47:0] pick_target(input int a);
    logic signed [47:0] v;
    case ($urandom_range(9))
      0: v = 48'({$urandom, $urandom}); // full 48 bit random
      1: v = last_tgt[a];
      2: v = last_tgt[a] + 48'($signed($urandom_range(65535)) - 32768);
      default: v = last_tgt[a] + 48'($signed({1'b0, $urandom_range(2000000)}) - 1000000);
    endcase
    return v;
  endfunction

  task automatic send_frame();
    logic [191:0] d;
    for (int a = 0; a < 4; a++) begin
      d[48*a +: 48] = pick_target(a);
      last_tgt[a] = d[48*a +: 48];
    end
    send_word(OP_ENQUEUE, d);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      // Mostly advances, with frames mixed in at random to keep the ring busy and
      // sometimes overflow it.
      if ($urandom_range(99) < 18) send_frame();
      else send_word(OP_ADVANCE, {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    end
  endtask

  initial begin
    logic [191:0] d;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = OP_ENQUEUE;
    s_axis_tdata = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int a = 0; a < 4; a++) last_tgt[a] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: advance on an empty ring, extremes, no-move, huge move.
    send_word(OP_ADVANCE, '0);
    send_word(OP_ADVANCE, '1);
    send_word(OP_ENQUEUE, {48'sh7FFFFFFFFFFF, 48'sh800000000000, 48'd0, 48'd65536});
    send_word(OP_ENQUEUE, {48'sh7FFFFFFFFFFF, 48'sh800000000000, 48'd0, 48'd65536});
    send_word(OP_ENQUEUE, {48'd1, 48'sh800000000000, 48'hFFFFFFFF8000, 48'd40000});
    send_word(OP_ENQUEUE, '0);
    for (int i = 0; i < 6; i++) send_word(OP_ADVANCE, '0);
    // Fill the ring past full so the last enqueues drop.
    for (int i = 0; i < 17; i++) begin
      d = {48'(i * 70000), 48'(-i * 33000), 48'(i * 123), 48'(i * 5000000)};
      send_word(OP_ENQUEUE, d);
    end
    last_tgt[0] = 48'(14 * 5000000);
    last_tgt[1] = 48'(14 * 123);
    last_tgt[2] = 48'(-14 * 33000);
    last_tgt[3] = 48'(14 * 70000);
    wait_drained();

    send_idle_pct = 37;
    recv_idle_pct = 45;
    random_phase(650);
    // Hold off until every expected result is in.
    wait_drained();
    send_idle_pct = 45;
    recv_idle_pct = 37;
    random_phase(650);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(650);

    wait_drained();
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
